// ===== rtl/sha1mh_pkg.sv =====
`timescale 1ns / 1ps

package sha1mh_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned ROUNDS      = 80;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] K0 = 32'h5A82_7999;
   localparam logic [31:0] K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K3 = 32'hCA62_C1D6;

   localparam logic [31:0] INIT_WORDS [DIGEST_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   typedef enum logic {
      CMD_WORD   = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_kind_type;

   // One queue entry: a full message word, or the closing word of a message
   // (0x80 already placed) together with the message length in bits.
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  word;
      logic [63:0]  bit_len;
   } cmd_type;

   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = K0;
      end else if (rnd < 7'd40) begin
         k = K1;
      end else if (rnd < 7'd60) begin
         k = K2;
      end else begin
         k = K3;
      end
      return k;
   endfunction

endpackage

// ===== rtl/sha1mh_front.sv =====
`timescale 1ns / 1ps

module sha1mh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [7:0]          req_data_byte,
   input  logic                q_full,
   output logic                q_push,
   output sha1mh_pkg::cmd_type q_cmd
);

   logic [63:0] count_ff, count_in;
   logic [31:0] part_ff, part_in;
   logic [1:0]  lane;
   logic        accept;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign lane      = count_ff[1:0];

   always_comb begin
      count_in = count_ff;
      part_in  = part_ff;
      q_push   = 1'b0;
      q_cmd.kind    = sha1mh_pkg::CMD_WORD;
      q_cmd.word    = {part_ff[31:8], req_data_byte};
      q_cmd.bit_len = {count_ff[60:0], 3'b000};
      if (accept) begin
         if (req_action == sha1mh_pkg::ACT_APPEND) begin
            count_in = count_ff + 64'd1;
            // drop the byte into its lane; push once the word is complete
            part_in[(5'd24 - {lane, 3'b000}) +: 8] = req_data_byte;
            q_push = (lane == 2'd3);
         end else begin
            count_in   = '0;
            q_push     = 1'b1;
            q_cmd.kind = sha1mh_pkg::CMD_FINISH;
            unique case (lane)
               2'd0: q_cmd.word = {sha1mh_pkg::PAD_BYTE, 24'h0};
               2'd1: q_cmd.word = {part_ff[31:24], sha1mh_pkg::PAD_BYTE, 16'h0};
               2'd2: q_cmd.word = {part_ff[31:16], sha1mh_pkg::PAD_BYTE, 8'h0};
               2'd3: q_cmd.word = {part_ff[31:8], sha1mh_pkg::PAD_BYTE};
               default: q_cmd.word = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      part_ff <= part_in;
   end

endmodule

// ===== rtl/sha1mh_queue.sv =====
`timescale 1ns / 1ps

module sha1mh_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sha1mh_pkg::cmd_type push_cmd,
   input  logic                pop,
   output sha1mh_pkg::cmd_type head_cmd,
   output logic                empty,
   output logic                full
);

   localparam int unsigned AW = sha1mh_pkg::QUEUE_AW;

   sha1mh_pkg::cmd_type entry_ff [sha1mh_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          do_push, do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (AW+1)'(sha1mh_pkg::QUEUE_DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/sha1mh_core.sv =====
`timescale 1ns / 1ps

module sha1mh_core (
   input  logic                clock,
   input  logic                reset,
   input  sha1mh_pkg::cmd_type q_head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);

   typedef enum logic [4:0] {
      ST_FILL  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [6:0]  rcnt_ff, rcnt_in;
   logic        fin_ff, fin_in;
   logic        last_ff, last_in;
   logic        lenph_ff, lenph_in;
   logic [63:0] blen_ff, blen_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [31:0] w_ff [16];
   logic [31:0] chain_ff [sha1mh_pkg::DIGEST_WORDS];
   logic [31:0] chain_in [sha1mh_pkg::DIGEST_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        shift_en;
   logic [31:0] shift_word;
   logic [31:0] sched_x, sched_word, round_sum;
   logic        start_round, out_load;

   assign sched_x    = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign sched_word = {sched_x[30:0], sched_x[31]};
   assign round_sum  = {a_ff[26:0], a_ff[31:27]} + sha1mh_pkg::round_f(rcnt_ff, b_ff, c_ff, d_ff)
                     + e_ff + sha1mh_pkg::round_k(rcnt_ff) + w_ff[0];
   assign out_load   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in    = state_ff;
      wcnt_in     = wcnt_ff;
      rcnt_in     = rcnt_ff;
      fin_in      = fin_ff;
      last_in     = last_ff;
      lenph_in    = lenph_ff;
      blen_in     = blen_ff;
      oidx_in     = oidx_ff;
      chain_in    = chain_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      shift_en    = 1'b0;
      shift_word  = '0;
      start_round = 1'b0;
      q_pop       = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_FILL: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               shift_en   = 1'b1;
               shift_word = q_head.word;
               wcnt_in    = wcnt_ff + 4'd1;
               if (q_head.kind == sha1mh_pkg::CMD_FINISH) begin
                  fin_in  = 1'b1;
                  blen_in = q_head.bit_len;
                  if (wcnt_ff == 4'd15) begin
                     start_round = 1'b1;
                  end else begin
                     state_in = ST_PAD;
                  end
               end else if (wcnt_ff == 4'd15) begin
                  start_round = 1'b1;
               end
            end
         end
         ST_PAD: begin
            shift_en = 1'b1;
            wcnt_in  = wcnt_ff + 4'd1;
            if (wcnt_ff == 4'd14) begin
               shift_word = blen_ff[63:32];
               lenph_in   = 1'b1;
            end else if (wcnt_ff == 4'd15) begin
               // either the low length word closes the final block, or the
               // 0x80 spilled past the length slot and an extra block runs
               shift_word  = lenph_ff ? blen_ff[31:0] : 32'h0;
               last_in     = lenph_ff;
               start_round = 1'b1;
            end
         end
         ST_ROUND: begin
            shift_en   = 1'b1;
            shift_word = sched_word;
            a_in = round_sum;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            rcnt_in = rcnt_ff + 7'd1;
            if (rcnt_ff == 7'(sha1mh_pkg::ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (fin_ff && last_ff) begin
               state_in = ST_OUT;
               oidx_in  = '0;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[oidx_ff];
               rsp_idx_in   = oidx_ff;
               rsp_last_in  = (oidx_ff == 3'(sha1mh_pkg::DIGEST_WORDS - 1));
               oidx_in      = oidx_ff + 3'd1;
               if (oidx_ff == 3'(sha1mh_pkg::DIGEST_WORDS - 1)) begin
                  chain_in = sha1mh_pkg::INIT_WORDS;
                  fin_in   = 1'b0;
                  last_in  = 1'b0;
                  lenph_in = 1'b0;
                  state_in = ST_FILL;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase

      if (start_round) begin
         state_in = ST_ROUND;
         rcnt_in  = '0;
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         wcnt_ff      <= '0;
         rcnt_ff      <= '0;
         fin_ff       <= 1'b0;
         last_ff      <= 1'b0;
         lenph_ff     <= 1'b0;
         oidx_ff      <= '0;
         chain_ff     <= sha1mh_pkg::INIT_WORDS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         rcnt_ff      <= rcnt_in;
         fin_ff       <= fin_in;
         last_ff      <= last_in;
         lenph_ff     <= lenph_in;
         oidx_ff      <= oidx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blen_ff     <= blen_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      // rolling schedule window: oldest word at the bottom, new word enters on top
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= shift_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule

// ===== rtl/sha1_message_hasher_top.sv =====
`timescale 1ns / 1ps

// SHA-1 hasher: feed a message one byte per transaction (action 0), then send
// a finish transaction (action 1); the block answers with the five 32-bit
// words of the 160-bit digest, most significant first, word_index 0..4,
// last_word set on the fifth, and is then ready for the next message with
// fresh initial values. The front end takes one byte per cycle, packs four
// bytes big-endian into a word and pushes it into a four-entry command
// queue; it only stalls when the queue is full. The back end pulls one word
// per cycle, while it is filling and the queue is not empty, into a 16-word
// rolling schedule window, then runs the 80 compression rounds one per cycle
// and adds the result into the chaining words in a separate add state. While
// a block compresses, the queue absorbs only 16 bytes of the next block
// before the front end stalls, so the remaining 48 bytes arrive at one per
// cycle once filling resumes; sustained throughput is set by the queue depth
// and the single round unit. A finish costs a padding phase, one or two
// compressions (two when fewer than nine byte slots remain in the last
// block), and the hand-out of the five digest words through the output
// register; the front end may already accept the next message meanwhile.

module sha1_message_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha1mh_pkg::cmd_type push_cmd;
   sha1mh_pkg::cmd_type head_cmd;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   // accept bytes, assemble words, classify finish
   sha1mh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // decouple front and back so each can stall on its own
   sha1mh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // schedule, rounds, padding and digest output
   sha1mh_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_head          (head_cmd),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ===== rtl/sha1mh_checker.sv =====
`timescale 1ns / 1ps

module sha1mh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_word_index) && $stable(rsp_last_word))
      else $error("stalled digest transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last_word does not match word_index");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_index <= 3'd4))
      else $error("word_index out of range");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind sha1_message_hasher_top sha1mh_checker u_sha1mh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // One input transaction: an action and its message byte.
   typedef struct packed {
      logic       action;
      logic [7:0] data;
   } hash_req_type;

   // One digest word as it should leave the block.
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = sha1mh_pkg::ACT_APPEND;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Transactions waiting to be offered, filled before reset is released.
   hash_req_type    byte_feed [$];
   // Digest words predicted but not yet seen on the result channel.
   digest_word_type digest_expect [$];

   // Shadow hash state.
   logic [31:0] chain_h [sha1mh_pkg::DIGEST_WORDS];
   logic [7:0]  block_bytes [64];
   logic [63:0] msg_bytes;

   int total_items = 0;
   int items_taken = 0;
   int pressure_at = 0;
   int mismatches = 0;

   logic            req_taken = 1'b0;
   logic            quiet_tail = 1'b0;
   int              send_gap = 0;
   int              stall_left = 0;
   int              hold_left = 0;
   logic            pressure_done = 1'b0;
   hash_req_type    next_item;
   digest_word_type want_word;

   sha1_message_hasher_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Run the 80 rounds over the shadow block and fold into the chain.
   task automatic sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int t = 0; t < 16; t++) begin
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w[t % 16] = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = sha1mh_pkg::K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1mh_pkg::K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1mh_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1mh_pkg::K3;
         end
         tmp = rotl(a, 5) + f + e + k + w[t % 16];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endtask

   task automatic start_message();
      for (int i = 0; i < sha1mh_pkg::DIGEST_WORDS; i++) chain_h[i] = sha1mh_pkg::INIT_WORDS[i];
      msg_bytes = '0;
   endtask

   // Absorb one accepted transaction; a finish queues the five digest words.
   task automatic sha1_absorb(input logic act, input logic [7:0] data);
      logic [5:0]      pos;
      logic [63:0]     bit_len;
      digest_word_type dw;
      pos = msg_bytes[5:0];
      if (act == sha1mh_pkg::ACT_APPEND) begin
         block_bytes[pos] = data;
         msg_bytes = msg_bytes + 64'd1;
         if (pos == 6'd63) sha1_compress();
      end else begin
         bit_len = msg_bytes << 3;
         block_bytes[pos] = sha1mh_pkg::PAD_BYTE;
         for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
         // no room left for the length: close this block and pad another
         if (pos >= 6'd56) begin
            sha1_compress();
            for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[8*(7-i) +: 8];
         sha1_compress();
         for (int i = 0; i < sha1mh_pkg::DIGEST_WORDS; i++) begin
            dw.word  = chain_h[i];
            dw.index = 3'(i);
            dw.last  = (i == sha1mh_pkg::DIGEST_WORDS - 1);
            digest_expect.push_back(dw);
         end
         start_message();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic push_item(input logic act, input logic [7:0] data);
      hash_req_type it;
      it.action = act;
      it.data   = data;
      byte_feed.push_back(it);
      total_items++;
   endtask

   // Queue a message of random bytes and its finish; the finish byte is noise.
   task automatic push_message(input int len);
      for (int i = 0; i < len; i++) begin
         push_item(sha1mh_pkg::ACT_APPEND, 8'($urandom_range(0, 255)));
      end
      push_item(sha1mh_pkg::ACT_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // Sample both handshakes at the rising edge; predict inputs, check outputs.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h index %0d",
                                         rsp_digest_word, rsp_word_index));
            end else begin
               want_word = digest_expect.pop_front();
               if (rsp_digest_word !== want_word.word)
                  report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                            rsp_digest_word, want_word.word, want_word.index));
               if (rsp_word_index !== want_word.index)
                  report_mismatch($sformatf("word_index %0d, want %0d",
                                            rsp_word_index, want_word.index));
               if (rsp_last_word !== want_word.last)
                  report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                            rsp_last_word, want_word.last, want_word.index));
            end
         end
         if (req_valid && !req_stall) begin
            sha1_absorb(req_action, req_data_byte);
            items_taken <= items_taken + 1;
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   // Driver: advance on acceptance, hold while stalled, drop valid in idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled transaction as it is
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_valid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
         if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
            req_valid <= 1'b0;
         end else begin
            next_item = byte_feed.pop_front();
            req_valid     <= 1'b1;
            req_action    <= next_item.action;
            req_data_byte <= next_item.data;
         end
      end else begin
         req_valid <= 1'b0;
      end
      // calm ending: no idling on either side once the feed runs low
      quiet_tail <= (byte_feed.size() < 40);
   end

   // Receiver: one long hold-off to back the block up, then random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!pressure_done && items_taken >= pressure_at) begin
         pressure_done = 1'b1;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else if (quiet_tail) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int pick;
      int len;
      start_message();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

      // empty message
      push_item(sha1mh_pkg::ACT_FINISH, 8'h00);
      // byte extremes and alternating patterns
      push_item(sha1mh_pkg::ACT_APPEND, 8'h00);
      push_item(sha1mh_pkg::ACT_APPEND, 8'hFF);
      push_item(sha1mh_pkg::ACT_APPEND, 8'hA5);
      push_item(sha1mh_pkg::ACT_APPEND, 8'h5A);
      push_item(sha1mh_pkg::ACT_FINISH, 8'hFF);
      // "abc"
      push_item(sha1mh_pkg::ACT_APPEND, 8'h61);
      push_item(sha1mh_pkg::ACT_APPEND, 8'h62);
      push_item(sha1mh_pkg::ACT_APPEND, 8'h63);
      push_item(sha1mh_pkg::ACT_FINISH, 8'h00);
      // a run of all-ones bytes
      for (int i = 0; i < 12; i++) push_item(sha1mh_pkg::ACT_APPEND, 8'hFF);
      push_item(sha1mh_pkg::ACT_FINISH, 8'h7F);
      pressure_at = total_items;

      // Pad boundaries: length just fits, length spills into a second block,
      // and an exactly full block.
      push_message(55);
      push_message(61);
      push_message(64);
      while (total_items < 310) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) len = $urandom_range(0, 12);
         else if (pick < 8) len = $urandom_range(52, 66);
         else if (pick < 9) len = $urandom_range(112, 128);
         else len = $urandom_range(0, 70);
         // trim the last message so the run ends near its item budget
         if (len > 309 - total_items) len = 309 - total_items;
         push_message(len);
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (items_taken != total_items) @(posedge clock);
      while (digest_expect.size() != 0) @(posedge clock);
      // watch a while longer for stray digest words
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS sha1_message_hasher_top");
      end else begin
         $display("FAIL sha1_message_hasher_top");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAIL sha1_message_hasher_top");
      $finish;
   end

endmodule
